// File: rtl/tpag_pkg.sv
// ----------------------------------------------------------------------------
// tpag_pkg: shared types and constants of the tensor permute address generator
// Holds layout limits, configuration register codes, the setup-to-walker
// bundle and the dimension size helper.
// ----------------------------------------------------------------------------
package tpag_pkg;

  // Layout limits
  localparam int MAX_DIMS    = 8;
  localparam int SIZE_BITS   = 16;
  localparam int OFFSET_BITS = 32;

  // Slots addressed by the three-bit permutation entries
  localparam int SLOTS      = 8;
  localparam int SLOT_BITS  = 3;
  localparam int DIM_BITS   = 4;
  localparam int FIELD_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 64;
  localparam int PERM_BITS     = SLOTS * SLOT_BITS;

  // Configuration register codes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DIM_COUNT   = 2'd0,
    REG_SIZES_LOWER = 2'd1,
    REG_SIZES_UPPER = 2'd2,
    REG_PERM_MAP    = 2'd3
  } cfg_reg_t;

  // Reset values
  localparam logic [DIM_BITS-1:0]   DIM_COUNT_RST = 4'd1;
  localparam logic [FIELD_BITS-1:0] SIZE_RST      = 16'd1;
  localparam logic [PERM_BITS-1:0]  PERM_IDENTITY = 24'hFAC688;

  // Tables handed from the setup sequencer to the element walker
  typedef struct packed {
    logic                                  restart;
    logic                                  ready;
    logic [DIM_BITS-1:0]                   dims;
    logic [SLOTS-1:0][SIZE_BITS-1:0]       size_last;
    logic [SLOTS-1:0][OFFSET_BITS-1:0]     delta;
  } tables_t;

  // Take the used bits of a size field; a zero size counts as one
  function automatic logic [SIZE_BITS-1:0] fix_size(input logic [FIELD_BITS-1:0] field);
    logic [SIZE_BITS-1:0] s;
    s = field[SIZE_BITS-1:0];
    return (s == '0) ? SIZE_BITS'(1) : s;
  endfunction

endpackage

// File: rtl/tpag_setup.sv
// ----------------------------------------------------------------------------
// tpag_setup: configuration registers and stride/delta sequencer
// Stores the layout registers and, after reset or any register write, walks
// the output positions to build strides, then the carry levels to build the
// per-level offset deltas, one multiply per cycle.
// ----------------------------------------------------------------------------
module tpag_setup (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [tpag_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [tpag_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output tpag_pkg::tables_t                      tables
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_STRIDE = 4'b0010,
    S_DELTA  = 4'b0100,
    S_READY  = 4'b1000
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  logic [tpag_pkg::DIM_BITS-1:0]                                   dim_count_r;
  logic [tpag_pkg::SLOTS-1:0][tpag_pkg::FIELD_BITS-1:0]            sizes_r;
  logic [tpag_pkg::SLOTS-1:0][tpag_pkg::SLOT_BITS-1:0]             perm_r;

  logic [tpag_pkg::SLOTS-1:0][tpag_pkg::OFFSET_BITS-1:0]           stride_r;
  logic [tpag_pkg::SLOTS-1:0][tpag_pkg::OFFSET_BITS-1:0]           delta_r;
  logic [tpag_pkg::SLOTS-1:0][tpag_pkg::SIZE_BITS-1:0]             size_last_r;
  logic [tpag_pkg::OFFSET_BITS-1:0]                                prod_r;
  logic [tpag_pkg::OFFSET_BITS-1:0]                                sum_r;
  logic [tpag_pkg::DIM_BITS-1:0]                                   pos_r;
  logic [tpag_pkg::DIM_BITS-1:0]                                   dims_r;

  logic [tpag_pkg::DIM_BITS-1:0]                                   dims_use;
  logic [tpag_pkg::SLOT_BITS-1:0]                                  pos_m1;
  logic [tpag_pkg::SLOT_BITS-1:0]                                  perm_id;
  logic [tpag_pkg::SIZE_BITS-1:0]                                  perm_size;
  logic [tpag_pkg::OFFSET_BITS+tpag_pkg::SIZE_BITS-1:0]            prod_full;
  logic [tpag_pkg::OFFSET_BITS+tpag_pkg::SIZE_BITS-1:0]            acc_full;

  // Clamp the dimension count to the supported maximum
  assign dims_use = (dim_count_r > tpag_pkg::DIM_BITS'(tpag_pkg::MAX_DIMS)) ?
                    tpag_pkg::DIM_BITS'(tpag_pkg::MAX_DIMS) : dim_count_r;

  // Current position and its operands
  assign pos_m1    = tpag_pkg::SLOT_BITS'(pos_r - 1'b1);
  assign perm_id   = perm_r[pos_m1];
  assign perm_size = tpag_pkg::fix_size(sizes_r[perm_id]);
  assign prod_full = prod_r * perm_size;
  assign acc_full  = stride_r[pos_m1] * size_last_r[pos_m1];

  // Next sequencer state; a register write restarts the sweep
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  state_nxt = (dims_use == '0) ? S_READY : S_STRIDE;
      S_STRIDE: if (pos_r == tpag_pkg::DIM_BITS'(1)) state_nxt = S_DELTA;
      S_DELTA:  if (pos_r == tpag_pkg::DIM_BITS'(1)) state_nxt = S_READY;
      S_READY:  state_nxt = S_READY;
    endcase
    if (cfg_we) state_nxt = S_CLEAR;
  end

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= tpag_pkg::DIM_COUNT_RST;
      sizes_r     <= {tpag_pkg::SLOTS{tpag_pkg::SIZE_RST}};
      perm_r      <= tpag_pkg::PERM_IDENTITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpag_pkg::REG_DIM_COUNT:   dim_count_r <= cfg_data[tpag_pkg::DIM_BITS-1:0];
        tpag_pkg::REG_SIZES_LOWER: sizes_r[3:0] <= cfg_data;
        tpag_pkg::REG_SIZES_UPPER: sizes_r[7:4] <= cfg_data;
        tpag_pkg::REG_PERM_MAP:    perm_r <= cfg_data[tpag_pkg::PERM_BITS-1:0];
      endcase
    end
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Build strides and deltas
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_CLEAR: begin
        stride_r <= '0;
        delta_r  <= '0;
        prod_r   <= tpag_pkg::OFFSET_BITS'(1);
        sum_r    <= '0;
        pos_r    <= dims_use;
        dims_r   <= dims_use;
        for (int d = 0; d < tpag_pkg::SLOTS; d++) begin
          size_last_r[d] <= tpag_pkg::fix_size(sizes_r[d]) - 1'b1;
        end
      end
      S_STRIDE: begin
        // Walk output positions from the innermost out
        stride_r[perm_id] <= prod_r;
        prod_r            <= prod_full[tpag_pkg::OFFSET_BITS-1:0];
        pos_r             <= (pos_r == tpag_pkg::DIM_BITS'(1)) ? dims_r : pos_r - 1'b1;
      end
      S_DELTA: begin
        // Subtract the span of all inner dimensions from this stride
        delta_r[pos_m1] <= stride_r[pos_m1] - sum_r;
        sum_r           <= sum_r + acc_full[tpag_pkg::OFFSET_BITS-1:0];
        pos_r           <= pos_r - 1'b1;
      end
      S_READY: begin
        pos_r <= pos_r;
      end
    endcase
  end

  assign tables.restart   = cfg_we;
  assign tables.ready     = (state_r == S_READY);
  assign tables.dims      = dims_r;
  assign tables.size_last = size_last_r;
  assign tables.delta     = delta_r;

endmodule

// File: rtl/tpag_walker.sv
// ----------------------------------------------------------------------------
// tpag_walker: element index counter and result register
// Steps the multi-dimensional index once per request, adds the delta of the
// carry level to the running offset and registers the result.
// ----------------------------------------------------------------------------
module tpag_walker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tpag_pkg::tables_t                    tables,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [63:0]                          in_element_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [63:0]                          out_value_out,
  output logic [31:0]                          out_output_offset,
  output logic                                 out_final_element
);

  logic [tpag_pkg::SLOTS-1:0][tpag_pkg::SIZE_BITS-1:0] cnt_r;
  logic [tpag_pkg::OFFSET_BITS-1:0]                    ofs_r;
  logic [tpag_pkg::OFFSET_BITS-1:0]                    ofs_nxt;
  logic                                                out_valid_r;
  logic [63:0]                                         value_r;
  logic [31:0]                                         offset_r;
  logic                                                final_r;

  logic [tpag_pkg::SLOTS-1:0]                          can_step;
  logic                                                found;
  logic [tpag_pkg::SLOT_BITS-1:0]                      carry_at;
  logic                                                accept;

  // Stall while tables are rebuilt or the result register is held
  assign in_stall = !tables.ready || tables.restart || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // Find the innermost dimension that can still advance
  always_comb begin
    found    = 1'b0;
    carry_at = '0;
    for (int d = 0; d < tpag_pkg::SLOTS; d++) begin
      can_step[d] = (tpag_pkg::DIM_BITS'(d) < tables.dims) &&
                    (cnt_r[d] < tables.size_last[d]);
      if (can_step[d]) begin
        found    = 1'b1;
        carry_at = tpag_pkg::SLOT_BITS'(d);
      end
    end
  end

  assign ofs_nxt = ofs_r + tables.delta[carry_at];

  // Advance the index and the running offset
  always_ff @(posedge clk) begin
    if (!rst_n || tables.restart) begin
      cnt_r <= '0;
      ofs_r <= '0;
    end else if (accept) begin
      if (found) begin
        for (int d = 0; d < tpag_pkg::SLOTS; d++) begin
          if (tpag_pkg::SLOT_BITS'(d) > carry_at) cnt_r[d] <= '0;
        end
        cnt_r[carry_at] <= tpag_pkg::SIZE_BITS'(cnt_r[carry_at] + 1'b1);
        ofs_r           <= ofs_nxt;
      end else begin
        // Drop back to idle after the final element
        cnt_r <= '0;
        ofs_r <= '0;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r  <= in_element_value;
      offset_r <= 32'(ofs_r);
      final_r  <= !found;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value_out     = value_r;
  assign out_output_offset = offset_r;
  assign out_final_element = final_r;

endmodule

// File: rtl/tensor_permute_address_gen.sv
// Output: a result is registered and valid in the cycle after its request is accepted.
// Throughput: one element per cycle; in_stall rises only while the result
// register is held by out_stall or while the stride tables are rebuilt.
// Table rebuild: after reset and after every register write the setup sequencer
// runs its clear, stride and delta steps (one multiply per cycle) before input opens.
// Reset: synchronous, active-low rst_n; registers return to their reset layout.
// ----------------------------------------------------------------------------
// tensor_permute_address_gen: streaming address generator for a transpose
// Takes elements in input row-major order and returns each value with its
// offset in the permuted output tensor and a mark on the last element.
// ----------------------------------------------------------------------------
module tensor_permute_address_gen (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tpag_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tpag_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [63:0]                          in_element_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [63:0]                          out_value_out,
  output logic [31:0]                          out_output_offset,
  output logic                                 out_final_element
);

  tpag_pkg::tables_t tables;

  // Configuration and table build
  tpag_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tables    (tables)
  );

  // Per-element index walk
  tpag_walker u_walker (
    .clk               (clk),
    .rst_n             (rst_n),
    .tables            (tables),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value_out     (out_value_out),
    .out_output_offset (out_output_offset),
    .out_final_element (out_final_element)
  );

endmodule

// File: rtl/tpag_checker.sv
// ----------------------------------------------------------------------------
// tpag_checker: port-level checks of the tensor permute address generator
// Watches reset, configuration and both channels of the top level.
// ----------------------------------------------------------------------------
module tpag_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 cfg_we,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [63:0]                          out_value_out,
  input logic [31:0]                          out_output_offset,
  input logic                                 out_final_element
);

  // Input stays closed right after reset while tables are built
  a_stall_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");

  // A register write closes the input for the rebuild
  a_stall_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input open right after a register write");

  // Every accepted request shows up as a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  // A held result blocks new requests
  a_held_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("request accepted while result is held");

  // A stalled result keeps its payload
  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_value_out) &&
      $stable(out_output_offset) && $stable(out_final_element)))
    else $error("stalled result changed");

endmodule

bind tensor_permute_address_gen tpag_checker u_tpag_checker (.*);
